// ----- rtl/mau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mau_pkg
// Shared constants of the modular arithmetic unit: field widths, mode codes
// and the reset value of the modulus register.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int MOD_BITS_DEF = 32;
  localparam int EXP_BITS_DEF = 63;
  localparam int RES_W        = 32;
  localparam int MODE_W       = 2;

  localparam logic [63:0] MOD_RESET = 64'd1000000007;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_ADD = 2'd0;
  localparam mode_t MODE_SUB = 2'd1;
  localparam mode_t MODE_MUL = 2'd2;
  localparam mode_t MODE_POW = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/mau_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mau channel interfaces
// Valid/ready channels of the modular arithmetic unit: operation requests,
// residue results and modulus writes.
// ----------------------------------------------------------------------------
interface mau_in_if #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF,
  parameter int EXP_BITS = mau_pkg::EXP_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  mau_pkg::mode_t        mode;
  logic [MOD_BITS-1:0]   operand_a;
  logic [EXP_BITS-1:0]   operand_b;

  modport source (output valid, output mode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input mode, input operand_a, input operand_b,
                  output ready);
endinterface

interface mau_out_if;
  logic                      valid;
  logic                      ready;
  logic [mau_pkg::RES_W-1:0] residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

interface mau_cfg_if #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface
`default_nettype wire

// ----- rtl/modular_arithmetic_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Add, subtract, multiply or power modulo a programmable modulus, built
// around a bit-serial reducer and a bit-serial shift-add modular multiplier.
//
//   channel   dir   request
//   in_chan   in    mode, operand_a, operand_b
//   out_chan  out   residue
//   cfg_chan  in    modulus
//
// add/sub reduce operand_a, then operand_b, one bit per cycle, then add or
// subtract; multiply instead runs the one-bit-per-cycle shift-add multiplier.
// power reduces operand_a only, then scans the exponent from its LSB: a one
// bit multiplies the result by the base, and every bit squares the base.
// one request at a time; a new one is taken while a residue waits in the
// output register. synchronous reset restores the modulus to 1000000007.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF,
  parameter int EXP_BITS = mau_pkg::EXP_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mau_in_if.sink    in_chan,
  mau_out_if.source out_chan,
  mau_cfg_if.sink   cfg_chan
);
  import mau_pkg::*;

  localparam int M     = MOD_BITS;
  localparam int E     = EXP_BITS;
  localparam int MAXW  = (M > E) ? M : E;
  localparam int CNT_W = $clog2(MAXW + 1);
  localparam logic [63:0] MOD_RESET_V = MOD_RESET;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RED_A = 3'd1;
  localparam logic [2:0] ST_RED_B = 3'd2;
  localparam logic [2:0] ST_ARITH = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_PCHK  = 3'd5;
  localparam logic [2:0] ST_PMUL  = 3'd6;
  localparam logic [2:0] ST_PSQ   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             done_r, done_nxt;
  logic [M-1:0]     mod_r;
  mode_t            mode_r, mode_nxt;
  logic [M-1:0]     a_sh_r, a_sh_nxt;
  logic [E-1:0]     b_sh_r, b_sh_nxt;
  logic [M-1:0]     acc_r, acc_nxt;
  logic [M-1:0]     x_r, x_nxt;
  logic [M-1:0]     y_r, y_nxt;
  logic [M-1:0]     base_r, base_nxt;
  logic [M-1:0]     res_r, res_nxt;
  logic [M-1:0]     fin_r, fin_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r;
  logic [RES_W-1:0] out_res_r;

  logic [M-1:0]     m_e;
  logic [M:0]       red_t;
  logic [M-1:0]     red_v;
  logic [M+1:0]     mul_s;
  logic [M+1:0]     m_x1, m_x2;
  logic [M-1:0]     mul_v;
  logic [M-1:0]     gap;
  logic [M-1:0]     add_v, sub_v;
  logic             last;
  logic             red_bit;
  logic             out_free;
  logic [RES_W+M-1:0] fin_ext;

  assign m_e = (mod_r == '0) ? {{(M-1){1'b0}}, 1'b1} : mod_r;

  // one step of bit-serial reduction
  assign red_bit = (state_r == ST_RED_A) ? a_sh_r[M-1] : b_sh_r[E-1];
  assign red_t   = {acc_r, red_bit};
  assign red_v   = (red_t >= {1'b0, m_e}) ? M'(red_t - {1'b0, m_e}) : red_t[M-1:0];

  // one step of shift-add modular multiplication
  assign m_x1  = {2'b00, m_e};
  assign m_x2  = {1'b0, m_e, 1'b0};
  assign mul_s = {1'b0, acc_r, 1'b0} + (y_r[M-1] ? {2'b00, x_r} : '0);
  always_comb begin
    if (mul_s >= m_x2) begin
      mul_v = M'(mul_s - m_x2);
    end else if (mul_s >= m_x1) begin
      mul_v = M'(mul_s - m_x1);
    end else begin
      mul_v = mul_s[M-1:0];
    end
  end

  assign gap   = m_e - acc_r;
  assign add_v = (base_r >= gap) ? (base_r - gap) : (base_r + acc_r);
  assign sub_v = (base_r >= acc_r) ? (base_r - acc_r) : (base_r + gap);

  assign last     = (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1});
  assign out_free = !ov_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    mode_nxt  = mode_r;
    a_sh_nxt  = a_sh_r;
    b_sh_nxt  = b_sh_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    base_nxt  = base_r;
    res_nxt   = res_r;
    fin_nxt   = fin_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (done_r) begin
          if (out_free) begin
            done_nxt = 1'b0;
          end
        end else if (in_chan.valid) begin
          mode_nxt  = in_chan.mode;
          a_sh_nxt  = in_chan.operand_a;
          b_sh_nxt  = in_chan.operand_b;
          acc_nxt   = '0;
          cnt_nxt   = CNT_W'(M);
          state_nxt = ST_RED_A;
        end
      end
      ST_RED_A: begin
        acc_nxt  = red_v;
        a_sh_nxt = a_sh_r << 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (last) begin
          base_nxt = red_v;
          acc_nxt  = '0;
          if (mode_r == MODE_POW) begin
            res_nxt   = (m_e == {{(M-1){1'b0}}, 1'b1}) ? '0 : {{(M-1){1'b0}}, 1'b1};
            state_nxt = ST_PCHK;
          end else begin
            cnt_nxt   = CNT_W'(E);
            state_nxt = ST_RED_B;
          end
        end
      end
      ST_RED_B: begin
        acc_nxt  = red_v;
        b_sh_nxt = b_sh_r << 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (last) begin
          if (mode_r == MODE_MUL) begin
            x_nxt     = base_r;
            y_nxt     = red_v;
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(M);
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_ARITH;
          end
        end
      end
      ST_ARITH: begin
        fin_nxt   = (mode_r == MODE_SUB) ? sub_v : add_v;
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_PCHK: begin
        acc_nxt = '0;
        cnt_nxt = CNT_W'(M);
        if (b_sh_r == '0) begin
          fin_nxt   = res_r;
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (b_sh_r[0]) begin
          x_nxt     = res_r;
          y_nxt     = base_r;
          state_nxt = ST_PMUL;
        end else begin
          x_nxt     = base_r;
          y_nxt     = base_r;
          state_nxt = ST_PSQ;
        end
      end
      ST_MUL, ST_PMUL, ST_PSQ: begin
        acc_nxt = mul_v;
        y_nxt   = y_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (last) begin
          if (state_r == ST_MUL) begin
            fin_nxt   = mul_v;
            done_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else if (state_r == ST_PMUL) begin
            res_nxt   = mul_v;
            x_nxt     = base_r;
            y_nxt     = base_r;
            acc_nxt   = '0;
            cnt_nxt   = CNT_W'(M);
            state_nxt = ST_PSQ;
          end else begin
            base_nxt  = mul_v;
            b_sh_nxt  = b_sh_r >> 1;
            state_nxt = ST_PCHK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready  = (state_r == ST_IDLE) && !done_r;
  assign cfg_chan.ready = 1'b1;

  assign fin_ext = {{RES_W{1'b0}}, fin_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
      mod_r   <= MOD_RESET_V[M-1:0];
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_chan.valid) begin
        mod_r <= cfg_chan.modulus;
      end
      if (done_r && out_free) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    a_sh_r <= a_sh_nxt;
    b_sh_r <= b_sh_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
    fin_r  <= fin_nxt;
    if (done_r && out_free) begin
      out_res_r <= fin_ext[RES_W-1:0];
    end
  end

  assign out_chan.valid   = ov_r;
  assign out_chan.residue = out_res_r;

endmodule
`default_nettype wire
